>>> hdl/ltsv_pkg.sv
// Shared types, widths and codes for the leg target speed vector block.
package ltsv_pkg;

  localparam int LEG_COUNT  = 4;
  localparam int LEG_W      = 2;
  localparam int AXES       = 3;
  localparam int AXIS_W     = 2;
  localparam int COORD_W    = 16;
  localparam int DELTA_W    = COORD_W + 1;
  localparam int MAG_W      = 16;
  localparam int SPEED_W    = 33;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 1;

  // Arithmetic widths of the sequenced datapath
  localparam int SUM_W  = 34;            // dx^2 + dy^2 + dz^2
  localparam int RAD_W  = SUM_W + 16;    // radicand, sum scaled by 2^16
  localparam int ROOT_W = RAD_W / 2;     // square root of the radicand
  localparam int REM_W  = ROOT_W + 1;    // root and divide remainder
  localparam int SUB_W  = REM_W + 1;     // shared subtractor operands
  localparam int P_W    = 32;            // base speed * speed multiplier
  localparam int PROD_W = MAG_W + P_W;   // shared multiplier product
  localparam int QUO_W  = 32;            // quotient bits per axis
  localparam int CNT_W  = 5;

  // Stream payload widths
  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 152;
  localparam int OUT_USER_W = 3;

  localparam logic [CFG_W-1:0] RESET_SPEED = 16'd256;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_BASE_SPEED = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_MULT = 1'd1;

  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [SPEED_W-1:0] speed_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_P_MUL,
    ST_ROOT_SETUP,
    ST_ROOT,
    ST_N_MUL,
    ST_DIV_SETUP,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } core_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic zero_length;
  } core_sts_t;

endpackage

>>> hdl/ltsv_core.sv
// Sequenced datapath: squared length, square root and per-axis division.
module ltsv_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ltsv_pkg::core_ctl_t                    ctl,
  input  ltsv_pkg::delta_t [ltsv_pkg::AXES-1:0]  delta,
  input  logic [ltsv_pkg::CFG_W-1:0]             base_speed,
  input  logic [ltsv_pkg::CFG_W-1:0]             speed_mult,
  output ltsv_pkg::core_sts_t                    sts,
  output ltsv_pkg::speed_t [ltsv_pkg::AXES-1:0]  speed
);

  localparam int LAST_AXIS = ltsv_pkg::AXES - 1;

  ltsv_pkg::state_t state_r, state_nxt;

  logic [ltsv_pkg::AXES-1:0][ltsv_pkg::MAG_W-1:0] mag_r, mag_nxt;
  logic [ltsv_pkg::AXES-1:0]                      neg_r, neg_nxt;
  logic [ltsv_pkg::AXIS_W-1:0]                    axis_r, axis_nxt;
  logic [ltsv_pkg::CNT_W-1:0]                     cnt_r, cnt_nxt;
  logic [ltsv_pkg::SUM_W-1:0]                     sum_r, sum_nxt;
  logic [ltsv_pkg::P_W-1:0]                       p_r, p_nxt;
  logic [ltsv_pkg::RAD_W-1:0]                     rad_r, rad_nxt;
  logic [ltsv_pkg::ROOT_W-1:0]                    root_r, root_nxt;
  logic [ltsv_pkg::REM_W-1:0]                     rem_r, rem_nxt;
  logic [ltsv_pkg::QUO_W-1:0]                     num_r, num_nxt;
  logic [ltsv_pkg::QUO_W-1:0]                     quo_r, quo_nxt;
  logic [ltsv_pkg::PROD_W-1:0]                    mul_r, mul_nxt;
  ltsv_pkg::speed_t [ltsv_pkg::AXES-1:0]          speed_r, speed_nxt;
  logic                                           zero_r, zero_nxt;

  logic [ltsv_pkg::MAG_W-1:0] mul_a;
  logic [ltsv_pkg::P_W-1:0]   mul_b;
  logic [ltsv_pkg::SUB_W-1:0] sub_a, sub_b;
  logic [ltsv_pkg::SUB_W:0]   diff;
  logic                       ge;
  logic [ltsv_pkg::QUO_W-1:0] quo_fin;
  logic [ltsv_pkg::MAG_W-1:0] mag_cur;

  assign mag_cur = mag_r[axis_r];

  // Shared multiplier
  always_comb begin
    case (state_r)
      ltsv_pkg::ST_SQ_MUL: begin
        mul_a = mag_cur;
        mul_b = {{(ltsv_pkg::P_W-ltsv_pkg::MAG_W){1'b0}}, mag_cur};
      end
      ltsv_pkg::ST_P_MUL: begin
        mul_a = base_speed;
        mul_b = {{(ltsv_pkg::P_W-ltsv_pkg::CFG_W){1'b0}}, speed_mult};
      end
      ltsv_pkg::ST_N_MUL: begin
        mul_a = mag_cur;
        mul_b = p_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_nxt = ltsv_pkg::PROD_W'(mul_a) * ltsv_pkg::PROD_W'(mul_b);
  end

  // Shared trial subtractor for root and divide steps
  always_comb begin
    case (state_r)
      ltsv_pkg::ST_ROOT: begin
        sub_a = {rem_r[ltsv_pkg::REM_W-2:0], rad_r[ltsv_pkg::RAD_W-1 -: 2]};
        sub_b = {1'b0, root_r[ltsv_pkg::ROOT_W-2:0], 2'b01};
      end
      ltsv_pkg::ST_DIV: begin
        sub_a = {1'b0, rem_r[ltsv_pkg::REM_W-2:0], num_r[ltsv_pkg::QUO_W-1]};
        sub_b = {2'b00, root_r};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = ~diff[ltsv_pkg::SUB_W];
  end

  assign quo_fin = {quo_r[ltsv_pkg::QUO_W-2:0], ge};

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    p_nxt     = p_r;
    rad_nxt   = rad_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    speed_nxt = speed_r;
    zero_nxt  = zero_r;
    case (state_r)
      ltsv_pkg::ST_IDLE: begin
        if (ctl.start) begin
          for (int a = 0; a < ltsv_pkg::AXES; a++) begin
            neg_nxt[a] = delta[a][ltsv_pkg::DELTA_W-1];
            mag_nxt[a] = ltsv_pkg::MAG_W'((delta[a] ^ {ltsv_pkg::DELTA_W{neg_nxt[a]}})
                         + ltsv_pkg::DELTA_W'(neg_nxt[a]));
          end
          sum_nxt   = '0;
          axis_nxt  = '0;
          zero_nxt  = 1'b0;
          state_nxt = ltsv_pkg::ST_SQ_MUL;
        end
      end
      ltsv_pkg::ST_SQ_MUL: begin
        state_nxt = ltsv_pkg::ST_SQ_ACC;
      end
      ltsv_pkg::ST_SQ_ACC: begin
        sum_nxt = sum_r + ltsv_pkg::SUM_W'(mul_r[2*ltsv_pkg::MAG_W-1:0]);
        if (axis_r == ltsv_pkg::AXIS_W'(LAST_AXIS)) begin
          axis_nxt  = '0;
          state_nxt = ltsv_pkg::ST_P_MUL;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ltsv_pkg::ST_SQ_MUL;
        end
      end
      ltsv_pkg::ST_P_MUL: begin
        state_nxt = ltsv_pkg::ST_ROOT_SETUP;
      end
      ltsv_pkg::ST_ROOT_SETUP: begin
        p_nxt = mul_r[ltsv_pkg::P_W-1:0];
        if (sum_r == '0) begin
          // all deltas zero: flag it and report zero speeds
          zero_nxt  = 1'b1;
          speed_nxt = '0;
          state_nxt = ltsv_pkg::ST_DONE;
        end else begin
          rad_nxt   = {sum_r, 16'd0};
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = ltsv_pkg::CNT_W'(ltsv_pkg::ROOT_W - 1);
          state_nxt = ltsv_pkg::ST_ROOT;
        end
      end
      ltsv_pkg::ST_ROOT: begin
        // one root bit per cycle, two radicand bits consumed
        root_nxt = {root_r[ltsv_pkg::ROOT_W-2:0], ge};
        rem_nxt  = ge ? diff[ltsv_pkg::REM_W-1:0] : sub_a[ltsv_pkg::REM_W-1:0];
        rad_nxt  = rad_r << 2;
        if (cnt_r == '0) begin
          state_nxt = ltsv_pkg::ST_N_MUL;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ltsv_pkg::ST_N_MUL: begin
        state_nxt = ltsv_pkg::ST_DIV_SETUP;
      end
      ltsv_pkg::ST_DIV_SETUP: begin
        // numerator is product << 8; its top bits are already below the root
        rem_nxt   = ltsv_pkg::REM_W'(mul_r[ltsv_pkg::PROD_W-1:ltsv_pkg::QUO_W-8]);
        num_nxt   = {mul_r[ltsv_pkg::QUO_W-9:0], 8'd0};
        quo_nxt   = '0;
        cnt_nxt   = ltsv_pkg::CNT_W'(ltsv_pkg::QUO_W - 1);
        state_nxt = ltsv_pkg::ST_DIV;
      end
      ltsv_pkg::ST_DIV: begin
        quo_nxt = quo_fin;
        rem_nxt = ge ? diff[ltsv_pkg::REM_W-1:0] : sub_a[ltsv_pkg::REM_W-1:0];
        num_nxt = num_r << 1;
        if (cnt_r == '0) begin
          speed_nxt[axis_r] = neg_r[axis_r] ? -ltsv_pkg::speed_t'({1'b0, quo_fin})
                                            :  ltsv_pkg::speed_t'({1'b0, quo_fin});
          if (axis_r == ltsv_pkg::AXIS_W'(LAST_AXIS)) begin
            state_nxt = ltsv_pkg::ST_DONE;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = ltsv_pkg::ST_N_MUL;
          end
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ltsv_pkg::ST_DONE: begin
        if (ctl.ack) begin
          state_nxt = ltsv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ltsv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ltsv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    axis_r  <= axis_nxt;
    cnt_r   <= cnt_nxt;
    sum_r   <= sum_nxt;
    p_r     <= p_nxt;
    rad_r   <= rad_nxt;
    root_r  <= root_nxt;
    rem_r   <= rem_nxt;
    num_r   <= num_nxt;
    quo_r   <= quo_nxt;
    mul_r   <= mul_nxt;
    speed_r <= speed_nxt;
    zero_r  <= zero_nxt;
  end

  assign sts.idle        = (state_r == ltsv_pkg::ST_IDLE);
  assign sts.done        = (state_r == ltsv_pkg::ST_DONE);
  assign sts.zero_length = zero_r;
  assign speed           = speed_r;

endmodule

>>> hdl/leg_target_speed_vector.sv
// Leg target speed vector: stream ports, configuration, target store and result register.
//
// The input stream carries one beat per leg command: the new target and the
// leg's current position in in_tdata, the leg index and per-axis keep flags
// in in_tuser. For each beat one result beat leaves on the output stream with
// the per-axis speeds, the stored targets after the update, the leg index and
// a zero-length flag. Speeds are the axis deltas scaled by the base speed
// times the speed multiplier over the delta vector's length.
// From acceptance to out_tvalid an item passes through three squarings on
// the shared multiplier, the bit-serial square root and the restoring divider
// per axis, which share one trial subtractor; when all deltas are zero the
// root and divide steps are skipped. in_tready is high only while the
// sequencer is idle, so one item is in work at a time and a new beat is
// taken only once the previous item has left the sequencer.
// The result sits in an output register; when the receiver stalls the next
// item may still be accepted and worked on, and its result holds in the
// sequencer until the register frees. Reset (rst_n low, synchronous) clears
// the stored targets, empties the output and sets both speed registers to
// 1.0 (256). Write cfg registers only while the block is idle.
module leg_target_speed_vector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ltsv_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ltsv_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // target_x, target_y, target_z, now_x, now_y, now_z
  input  logic [ltsv_pkg::IN_DATA_W-1:0]     in_tdata,
  // leg, keep_x, keep_y, keep_z
  input  logic [ltsv_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // speed_x, speed_y, speed_z, expect_x, expect_y, expect_z, zero padding
  output logic [ltsv_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_leg, zero_length
  output logic [ltsv_pkg::OUT_USER_W-1:0]    out_tuser
);

  localparam int CW = ltsv_pkg::COORD_W;

  logic [ltsv_pkg::CFG_W-1:0] base_speed_r, speed_mult_r;
  logic [CW-1:0]              site_r [ltsv_pkg::LEG_COUNT][ltsv_pkg::AXES];

  logic [ltsv_pkg::LEG_W-1:0]                in_leg;
  logic [ltsv_pkg::AXES-1:0]                 in_keep;
  logic [ltsv_pkg::AXES-1:0][CW-1:0]         in_tgt, in_now, expect_val;
  ltsv_pkg::delta_t [ltsv_pkg::AXES-1:0]     delta;
  logic                                      leg_ok;
  logic                                      accept;

  logic [ltsv_pkg::LEG_W-1:0]                item_leg_r;
  logic [ltsv_pkg::AXES-1:0][CW-1:0]         item_expect_r;

  logic                                      out_tvalid_r;
  logic [ltsv_pkg::LEG_W-1:0]                out_leg_r;
  logic [ltsv_pkg::AXES-1:0][CW-1:0]         out_expect_r;
  ltsv_pkg::speed_t [ltsv_pkg::AXES-1:0]     out_speed_r;
  logic                                      out_zero_r;

  ltsv_pkg::core_ctl_t                       ctl;
  ltsv_pkg::core_sts_t                       sts;
  ltsv_pkg::speed_t [ltsv_pkg::AXES-1:0]     core_speed;
  logic                                      load_out;

  assign in_leg  = in_tuser[ltsv_pkg::LEG_W-1:0];
  assign in_keep = in_tuser[ltsv_pkg::LEG_W +: ltsv_pkg::AXES];
  assign leg_ok  = (32'(in_leg) < ltsv_pkg::LEG_COUNT);

  always_comb begin
    for (int a = 0; a < ltsv_pkg::AXES; a++) begin
      in_tgt[a] = in_tdata[a*CW +: CW];
      in_now[a] = in_tdata[(ltsv_pkg::AXES + a)*CW +: CW];
      if (in_keep[a]) begin
        delta[a]      = '0;
        expect_val[a] = leg_ok ? site_r[in_leg][a] : '0;
      end else begin
        delta[a]      = ltsv_pkg::delta_t'({in_tgt[a][CW-1], in_tgt[a]})
                      - ltsv_pkg::delta_t'({in_now[a][CW-1], in_now[a]});
        expect_val[a] = in_tgt[a];
      end
    end
  end

  assign in_tready = sts.idle;
  assign accept    = in_tvalid & in_tready;
  assign load_out  = sts.done & ctl.ack;
  assign ctl.start = accept;
  assign ctl.ack   = ~out_tvalid_r | out_tready;

  ltsv_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .delta      (delta),
    .base_speed (base_speed_r),
    .speed_mult (speed_mult_r),
    .sts        (sts),
    .speed      (core_speed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_speed_r <= ltsv_pkg::RESET_SPEED;
      speed_mult_r <= ltsv_pkg::RESET_SPEED;
    end else if (cfg_we) begin
      case (cfg_addr)
        ltsv_pkg::CFG_BASE_SPEED: base_speed_r <= cfg_wdata;
        ltsv_pkg::CFG_SPEED_MULT: speed_mult_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Write the updated targets as soon as the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < ltsv_pkg::LEG_COUNT; l++) begin
        for (int a = 0; a < ltsv_pkg::AXES; a++) begin
          site_r[l][a] <= '0;
        end
      end
    end else if (accept && leg_ok) begin
      for (int a = 0; a < ltsv_pkg::AXES; a++) begin
        site_r[in_leg][a] <= expect_val[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_leg_r    <= in_leg;
      item_expect_r <= expect_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_leg_r    <= item_leg_r;
      out_expect_r <= item_expect_r;
      out_speed_r  <= core_speed;
      out_zero_r   <= sts.zero_length;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_expect_r, out_speed_r};
  assign out_tuser  = {out_zero_r, out_leg_r};

endmodule
